[rtl/tdc_readout_word_parser_defines.svh]
// Assertion macros for the readout word parser.
// Both expect a signal named clk in the scope of use; TRWP_ASSERT also expects rst.
`ifndef TDC_READOUT_WORD_PARSER_DEFINES_SVH
`define TDC_READOUT_WORD_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TRWP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TRWP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRWP_ASSERT(lbl, prop, msg)
`define TRWP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[rtl/tdc_rwp_pkg.sv]
package tdc_rwp_pkg;

  localparam int ADDR_W = 3;
  localparam logic REG_CRATE_ID = 1'b0;

  localparam logic [3:0] TYPE_BLK_HDR = 4'd0;
  localparam logic [3:0] TYPE_BLK_TRL = 4'd1;
  localparam logic [3:0] TYPE_EVT_HDR = 4'd2;
  localparam logic [3:0] TYPE_TRIG    = 4'd3;
  localparam logic [3:0] TYPE_DATA    = 4'd7;

  localparam logic [2:0] ST_HIT          = 3'd0;
  localparam logic [2:0] ST_EVENT_START  = 3'd1;
  localparam logic [2:0] ST_EARLY_TRL    = 3'd2;
  localparam logic [2:0] ST_EVT_NO_BLK   = 3'd3;
  localparam logic [2:0] ST_SLOT_MISMATCH = 3'd4;
  localparam logic [2:0] ST_TIME_NO_HDR  = 3'd5;
  localparam logic [2:0] ST_DATA_NO_HDR  = 3'd6;

  typedef enum logic [2:0] {
    K_IGNORE,
    K_BLK_HDR,
    K_BLK_TRL,
    K_EVT_HDR,
    K_TRIG,
    K_DATA
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] crate_id;
    logic [4:0]  slot;
    logic [3:0]  board_no;
    logic [21:0] event_num;
    logic [47:0] trigger_time;
    logic [2:0]  group;
    logic [4:0]  channel;
    logic        edge_res;
    logic [9:0]  coarse;
    logic        half_step;
    logic [6:0]  fine;
  } result_t;

  function automatic kind_t classify(input logic [31:0] w);
    kind_t k;
    k = K_IGNORE;
    if (w[31]) begin
      case (w[30:27])
        TYPE_BLK_HDR: k = K_BLK_HDR;
        TYPE_BLK_TRL: k = K_BLK_TRL;
        TYPE_EVT_HDR: k = K_EVT_HDR;
        TYPE_TRIG:    k = K_TRIG;
        TYPE_DATA:    k = K_DATA;
        default:      k = K_IGNORE;
      endcase
    end
    return k;
  endfunction

endpackage

[rtl/tdc_rwp_if.sv]
interface tdc_rwp_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink (input valid, input data_word, output ready);
endinterface

interface tdc_rwp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] crate_id;
  logic [4:0]  slot;
  logic [3:0]  board_no;
  logic [21:0] event_num;
  logic [47:0] trigger_time;
  logic [2:0]  group;
  logic [4:0]  channel;
  logic        edge_res;
  logic [9:0]  coarse;
  logic        half_step;
  logic [6:0]  fine;

  modport source (output valid, output status, output crate_id, output slot,
                  output board_no, output event_num, output trigger_time,
                  output group, output channel, output edge_res, output coarse,
                  output half_step, output fine, input ready);
  modport sink (input valid, input status, input crate_id, input slot,
                input board_no, input event_num, input trigger_time,
                input group, input channel, input edge_res, input coarse,
                input half_step, input fine, output ready);
endinterface

[rtl/tdc_rwp_front.sv]
module tdc_rwp_front import tdc_rwp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word,
  input  logic        q_full,
  output push_t       push
);

  logic   fv;
  entry_t fentry;

  assign in_ready   = !fv || !q_full;
  assign push.valid = fv && !q_full;
  assign push.entry = fentry;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv <= 1'b1;
    end else if (push.valid) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fentry.kind <= classify(in_word);
      fentry.word <= in_word;
    end
  end

endmodule

[rtl/tdc_rwp_queue.sv]
module tdc_rwp_queue import tdc_rwp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output entry_t q_entry
);

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push.valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr] <= push.entry;
  end

endmodule

[rtl/tdc_rwp_back.sv]
module tdc_rwp_back import tdc_rwp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] crate_id,
  input  logic        q_valid,
  input  entry_t      q_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     result
);

  logic        block_open, block_open_next;
  logic [7:0]  events_left, events_left_next;
  logic [4:0]  cur_slot, cur_slot_next;
  logic [3:0]  cur_board, cur_board_next;
  logic [21:0] cur_event, cur_event_next;
  logic [47:0] cur_time, cur_time_next;
  logic [23:0] time_low_hold, time_low_hold_next;
  logic        expect_time_high, expect_time_high_next;

  logic        emit;
  result_t     res_next;
  logic [31:0] w;

  assign w   = q_entry.word;
  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    block_open_next       = block_open;
    events_left_next      = events_left;
    cur_slot_next         = cur_slot;
    cur_board_next        = cur_board;
    cur_event_next        = cur_event;
    cur_time_next         = cur_time;
    time_low_hold_next    = time_low_hold;
    expect_time_high_next = expect_time_high;
    emit                  = 1'b0;
    res_next              = '0;
    res_next.crate_id     = crate_id;
    res_next.slot         = cur_slot;
    res_next.board_no     = cur_board;
    res_next.event_num    = cur_event;

    if (expect_time_high) begin
      // word after a trigger time is the high half, whatever it looks like
      expect_time_high_next = 1'b0;
      cur_time_next         = {w[23:0], time_low_hold};
    end else begin
      case (q_entry.kind)
        K_BLK_HDR: begin
          cur_slot_next    = w[26:22];
          cur_board_next   = w[21:18];
          events_left_next = w[7:0];
          block_open_next  = 1'b1;
        end
        K_BLK_TRL: begin
          if (!block_open || events_left != 8'd0) begin
            emit            = 1'b1;
            res_next.status = ST_EARLY_TRL;
          end
          block_open_next  = 1'b0;
          events_left_next = 8'd0;
        end
        K_EVT_HDR: begin
          if (!block_open || events_left == 8'd0) begin
            emit             = 1'b1;
            res_next.status  = ST_EVT_NO_BLK;
            block_open_next  = 1'b0;
            events_left_next = 8'd0;
          end else if (w[26:22] != cur_slot) begin
            emit             = 1'b1;
            res_next.status  = ST_SLOT_MISMATCH;
            block_open_next  = 1'b0;
            events_left_next = 8'd0;
          end else begin
            emit               = 1'b1;
            events_left_next   = events_left - 8'd1;
            cur_event_next     = w[21:0];
            res_next.status    = ST_EVENT_START;
            res_next.event_num = w[21:0];
          end
        end
        K_TRIG: begin
          if (!block_open) begin
            emit             = 1'b1;
            res_next.status  = ST_TIME_NO_HDR;
            block_open_next  = 1'b0;
            events_left_next = 8'd0;
          end else begin
            time_low_hold_next    = w[23:0];
            expect_time_high_next = 1'b1;
          end
        end
        K_DATA: begin
          emit = 1'b1;
          if (!block_open) begin
            res_next.status  = ST_DATA_NO_HDR;
            events_left_next = 8'd0;
          end else begin
            res_next.status       = ST_HIT;
            res_next.trigger_time = cur_time;
            res_next.group        = w[26:24];
            res_next.channel      = w[23:19];
            res_next.edge_res     = w[18];
            res_next.coarse       = w[17:8];
            res_next.half_step    = w[7];
            res_next.fine         = w[6:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_open       <= 1'b0;
      events_left      <= 8'd0;
      cur_slot         <= 5'd0;
      cur_board        <= 4'd0;
      cur_event        <= 22'd0;
      cur_time         <= 48'd0;
      time_low_hold    <= 24'd0;
      expect_time_high <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        block_open       <= block_open_next;
        events_left      <= events_left_next;
        cur_slot         <= cur_slot_next;
        cur_board        <= cur_board_next;
        cur_event        <= cur_event_next;
        cur_time         <= cur_time_next;
        time_low_hold    <= time_low_hold_next;
        expect_time_high <= expect_time_high_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) result <= res_next;
  end

endmodule

[rtl/tdc_readout_word_parser.sv]
// channel   dir  transfer when         payload
// words     in   valid && ready        data_word
// results   out  valid && ready        status .. fine (one result item)
// apb       in   psel&penable&pwrite   readout_crate_id at addresses 0-3 (paddr MSB low)
//
// One word per cycle sustained while results are taken; a word's result passes
// through the front register, the queue memory, then into the result register.
// Throughput is set by the back state update, one word a cycle unless results stall.
// Synchronous reset clears all parser control state (data registers are not reset); no clearing pass.
// A stalled result only blocks the back; the queue and front keep taking
// words until the queue fills.
`include "tdc_readout_word_parser_defines.svh"

module tdc_readout_word_parser import tdc_rwp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  tdc_rwp_word_if.sink        words,
  tdc_rwp_result_if.source    results,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [31:0] crate_reg;
  push_t       push;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  entry_t      q_entry;
  result_t     result;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_CRATE_ID) ? crate_reg : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      crate_reg <= 32'd0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1] == REG_CRATE_ID) begin
      crate_reg <= pwdata;
    end
  end

  tdc_rwp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (words.valid),
    .in_ready (words.ready),
    .in_word  (words.data_word),
    .q_full   (q_full),
    .push     (push)
  );

  tdc_rwp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_entry (q_entry)
  );

  tdc_rwp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .crate_id  (crate_reg),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (q_pop),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .result    (result)
  );

  assign results.status       = result.status;
  assign results.crate_id     = result.crate_id;
  assign results.slot         = result.slot;
  assign results.board_no     = result.board_no;
  assign results.event_num    = result.event_num;
  assign results.trigger_time = result.trigger_time;
  assign results.group        = result.group;
  assign results.channel      = result.channel;
  assign results.edge_res     = result.edge_res;
  assign results.coarse       = result.coarse;
  assign results.half_step    = result.half_step;
  assign results.fine         = result.fine;

  `TRWP_ASSERT(a_no_overflow, push.valid |-> !q_full || q_pop, "queue overflow")
  `TRWP_ASSERT(a_pop_valid, q_pop |-> q_valid, "pop from empty queue")
  `TRWP_ASSERT_RST(a_rst_idle, rst |=> !results.valid, "result valid after reset")

endmodule
